// ===== rtl/core/prrts_pkg.sv =====
package prrts_pkg;

   // Table geometry. The field widths of the ports fix these values.
   localparam int MAX_ENTRIES = 8;
   localparam int IDX_W       = 3;
   localparam int CNT_W       = 4;
   localparam int PRI_W       = 6;
   localparam int TS_W        = 2;

   typedef logic [TS_W-1:0]  task_state_type;
   typedef logic [3:0]       action_type;
   typedef logic [2:0]       status_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [PRI_W-1:0] pri_type;

   localparam task_state_type TS_READY    = 2'd0;
   localparam task_state_type TS_RUNNING  = 2'd1;
   localparam task_state_type TS_SLEEPING = 2'd2;
   localparam task_state_type TS_DONE     = 2'd3;

   localparam action_type ACT_INIT    = 4'd0;
   localparam action_type ACT_CREATE  = 4'd1;
   localparam action_type ACT_FORK    = 4'd2;
   localparam action_type ACT_SETPRI  = 4'd3;
   localparam action_type ACT_SLEEP   = 4'd4;
   localparam action_type ACT_EXIT    = 4'd5;
   localparam action_type ACT_START   = 4'd6;
   localparam action_type ACT_TICK    = 4'd7;
   localparam action_type ACT_ENABLE  = 4'd8;
   localparam action_type ACT_DISABLE = 4'd9;

   localparam status_type STAT_DONE      = 3'd0;
   localparam status_type STAT_FULL      = 3'd1;
   localparam status_type STAT_NO_CUR    = 3'd2;
   localparam status_type STAT_UNKNOWN   = 3'd3;
   localparam status_type STAT_NO_SWITCH = 3'd4;

   localparam logic signed [6:0] NICE_MIN    = -7'sd20;
   localparam logic signed [6:0] NICE_MAX    = 7'sd19;
   localparam logic signed [6:0] NICE_OFFSET = 7'sd20;

   localparam cnt_type MAX_COUNT = CNT_W'(MAX_ENTRIES);

endpackage

// ===== rtl/core/priority_round_robin_task_scheduler.sv =====
// Priority task scheduler with round-robin tie breaking. The block keeps a table of up to
// eight tasks, each with a state (ready, running, sleeping, done) and a priority from 0 to 39,
// where lower is more urgent, together with the current task, the task count, an enable flag
// and an idle-present flag. Every request transaction carries one action and produces exactly
// one response transaction. The task states and priorities live in two small synchronous RAMs
// with one read and one write port each, and a sequencer walks them. A request is taken only
// while the sequencer is idle, but it may be taken while the previous response still waits on
// the rsp_ side. Simple actions (init, create, fork, set priority, sleep, exit, enable,
// disable) go from the execute step straight to the response step, as does a tick refused
// before any scan. Start and tick scan the table once, one entry per cycle through the RAM
// read port, then pass the scan end and pick steps. A switch away from a current task reads
// and rewrites the old task's state before it marks the new one running; a switch with no
// current task only marks the new one, and a scan that finds nothing goes to the response
// step. Entries never written are never read, so the RAMs need no clearing pass after reset.
module priority_round_robin_task_scheduler
   import prrts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_ready,
   input  logic [3:0] req_action,
   input  logic [2:0] req_task_id,
   input  logic signed [6:0] req_nice_value,

   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic [2:0] rsp_new_id,
   output logic       rsp_switched,
   output logic       rsp_prev_valid,
   output logic [2:0] rsp_prev_id,
   output logic       rsp_current_valid,
   output logic [2:0] rsp_current_id,
   output logic [3:0] rsp_count_out
);

   // Sequencer codes.
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_EXEC     = 4'd1;
   localparam logic [3:0] S_SCAN     = 4'd2;
   localparam logic [3:0] S_SCAN_END = 4'd3;
   localparam logic [3:0] S_PICK     = 4'd4;
   localparam logic [3:0] S_PREV_RD  = 4'd5;
   localparam logic [3:0] S_PREV_WR  = 4'd6;
   localparam logic [3:0] S_NEXT_WR  = 4'd7;
   localparam logic [3:0] S_RESP     = 4'd8;

   logic [3:0] state_ff, state_in;

   // Architectural state.
   cnt_type count_ff, count_in;
   idx_type cur_ff, cur_in;
   logic    cur_present_ff, cur_present_in;
   logic    enabled_ff, enabled_in;
   logic    idle_present_ff, idle_present_in;

   // Latched request.
   action_type act_ff, act_in;
   idx_type    tid_ff, tid_in;
   logic signed [6:0] nice_ff, nice_in;

   // Scan bookkeeping.
   idx_type scan_idx_ff, scan_idx_in;
   cnt_type scan_cnt_ff, scan_cnt_in;
   logic    pend_ff, pend_in;
   idx_type pend_idx_ff, pend_idx_in;
   logic    best_found_ff, best_found_in;
   idx_type best_idx_ff, best_idx_in;
   pri_type best_pri_ff, best_pri_in;

   // Result fields held until the response register is free.
   status_type res_status_ff, res_status_in;
   idx_type    res_new_id_ff, res_new_id_in;
   logic       res_switched_ff, res_switched_in;
   logic       res_prev_valid_ff, res_prev_valid_in;
   idx_type    res_prev_id_ff, res_prev_id_in;

   // Response register.
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   idx_type    rsp_new_id_ff, rsp_new_id_in;
   logic       rsp_switched_ff, rsp_switched_in;
   logic       rsp_prev_valid_ff, rsp_prev_valid_in;
   idx_type    rsp_prev_id_ff, rsp_prev_id_in;
   logic       rsp_cur_valid_ff, rsp_cur_valid_in;
   idx_type    rsp_cur_id_ff, rsp_cur_id_in;
   cnt_type    rsp_count_ff, rsp_count_in;

   // Table RAM ports.
   logic           st_we, pr_we;
   idx_type        st_waddr, pr_waddr, rd_addr;
   task_state_type st_wdata, st_rdata;
   pri_type        pr_wdata, pr_rdata;

   // Helpers.
   logic              req_fire;
   logic              rsp_free;
   logic signed [6:0] nice_clamped;
   logic signed [6:0] nice_biased;
   idx_type           scan_next;
   idx_type           start_idx;
   logic              cand_ok;
   idx_type           cand;
   logic              qualifies;

   prrts_ram #(
      .WIDTH(TS_W),
      .DEPTH(MAX_ENTRIES)
   ) u_status_ram (
      .clock  (clock),
      .wr_en  (st_we),
      .wr_addr(st_waddr),
      .wr_data(st_wdata),
      .rd_addr(rd_addr),
      .rd_data(st_rdata)
   );

   prrts_ram #(
      .WIDTH(PRI_W),
      .DEPTH(MAX_ENTRIES)
   ) u_priority_ram (
      .clock  (clock),
      .wr_en  (pr_we),
      .wr_addr(pr_waddr),
      .wr_data(pr_wdata),
      .rd_addr(rd_addr),
      .rd_data(pr_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // Nice is clamped to -20..19 and then moved to the priority range 0..39.
   always_comb begin
      if (nice_ff < NICE_MIN) begin
         nice_clamped = NICE_MIN;
      end else if (nice_ff > NICE_MAX) begin
         nice_clamped = NICE_MAX;
      end else begin
         nice_clamped = nice_ff;
      end
      nice_biased = nice_clamped + NICE_OFFSET;
   end

   // The scan wraps at the task count, not at the table size.
   assign scan_next = (({1'b0, scan_idx_ff} + 1'b1) < count_ff) ? scan_idx_ff + 1'b1 : '0;
   assign start_idx = (cur_present_ff && (({1'b0, cur_ff} + 1'b1) < count_ff)) ?
                      cur_ff + 1'b1 : '0;

   // The first ready or running entry of strictly lower priority wins, so ties go to the
   // entry met first after the current one.
   assign qualifies = pend_ff && ((st_rdata == TS_READY) || (st_rdata == TS_RUNNING)) &&
                      (!best_found_ff || (pr_rdata < best_pri_ff));

   // Candidate after the scan, falling back to the idle entry.
   always_comb begin
      if (best_found_ff) begin
         cand_ok = 1'b1;
         cand    = best_idx_ff;
      end else begin
         cand_ok = idle_present_ff;
         cand    = '0;
      end
   end

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      cur_in            = cur_ff;
      cur_present_in    = cur_present_ff;
      enabled_in        = enabled_ff;
      idle_present_in   = idle_present_ff;
      act_in            = act_ff;
      tid_in            = tid_ff;
      nice_in           = nice_ff;
      scan_idx_in       = scan_idx_ff;
      scan_cnt_in       = scan_cnt_ff;
      pend_in           = 1'b0;
      pend_idx_in       = pend_idx_ff;
      best_found_in     = best_found_ff;
      best_idx_in       = best_idx_ff;
      best_pri_in       = best_pri_ff;
      res_status_in     = res_status_ff;
      res_new_id_in     = res_new_id_ff;
      res_switched_in   = res_switched_ff;
      res_prev_valid_in = res_prev_valid_ff;
      res_prev_id_in    = res_prev_id_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_status_in     = rsp_status_ff;
      rsp_new_id_in     = rsp_new_id_ff;
      rsp_switched_in   = rsp_switched_ff;
      rsp_prev_valid_in = rsp_prev_valid_ff;
      rsp_prev_id_in    = rsp_prev_id_ff;
      rsp_cur_valid_in  = rsp_cur_valid_ff;
      rsp_cur_id_in     = rsp_cur_id_ff;
      rsp_count_in      = rsp_count_ff;
      st_we             = 1'b0;
      st_waddr          = cur_ff;
      st_wdata          = TS_READY;
      pr_we             = 1'b0;
      pr_waddr          = count_ff[IDX_W-1:0];
      pr_wdata          = '0;
      rd_addr           = scan_idx_ff;

      // Comparison of the entry read in the previous cycle.
      if (qualifies) begin
         best_found_in = 1'b1;
         best_idx_in   = pend_idx_ff;
         best_pri_in   = pr_rdata;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               act_in   = req_action;
               tid_in   = req_task_id;
               nice_in  = req_nice_value;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            res_status_in     = STAT_DONE;
            res_new_id_in     = '0;
            res_switched_in   = 1'b0;
            res_prev_valid_in = 1'b0;
            res_prev_id_in    = '0;
            state_in          = S_RESP;
            unique case (act_ff)
               ACT_INIT: begin
                  // The idle entry is written straight as running, but is not made the current task.
                  st_we           = 1'b1;
                  st_waddr        = '0;
                  st_wdata        = TS_RUNNING;
                  pr_we           = 1'b1;
                  pr_waddr        = '0;
                  pr_wdata        = '0;
                  count_in        = CNT_W'(1);
                  cur_in          = '0;
                  cur_present_in  = 1'b0;
                  enabled_in      = 1'b0;
                  idle_present_in = 1'b1;
               end
               ACT_CREATE, ACT_FORK: begin
                  if ((act_ff == ACT_FORK) && !cur_present_ff) begin
                     res_status_in = STAT_NO_CUR;
                  end else if (count_ff >= MAX_COUNT) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     st_we         = 1'b1;
                     st_waddr      = count_ff[IDX_W-1:0];
                     st_wdata      = TS_READY;
                     pr_we         = 1'b1;
                     pr_waddr      = count_ff[IDX_W-1:0];
                     pr_wdata      = '0;
                     res_new_id_in = count_ff[IDX_W-1:0];
                     count_in      = count_ff + 1'b1;
                  end
               end
               ACT_SETPRI: begin
                  if ({1'b0, tid_ff} >= count_ff) begin
                     res_status_in = STAT_UNKNOWN;
                  end else begin
                     pr_we    = 1'b1;
                     pr_waddr = tid_ff;
                     pr_wdata = nice_biased[PRI_W-1:0];
                  end
               end
               ACT_SLEEP, ACT_EXIT: begin
                  if (!cur_present_ff) begin
                     res_status_in = STAT_NO_CUR;
                  end else begin
                     st_we    = 1'b1;
                     st_waddr = cur_ff;
                     st_wdata = (act_ff == ACT_SLEEP) ? TS_SLEEPING : TS_DONE;
                  end
               end
               ACT_START, ACT_TICK: begin
                  best_found_in = 1'b0;
                  if ((act_ff == ACT_TICK) && (!enabled_ff || (count_ff == '0))) begin
                     res_status_in = STAT_NO_SWITCH;
                  end else if (count_ff == '0) begin
                     state_in = S_PICK;
                  end else begin
                     scan_idx_in = start_idx;
                     scan_cnt_in = '0;
                     state_in    = S_SCAN;
                  end
               end
               ACT_ENABLE: begin
                  enabled_in = 1'b1;
               end
               ACT_DISABLE: begin
                  enabled_in = 1'b0;
               end
               default: begin
               end
            endcase
         end

         S_SCAN: begin
            // Issue one read per cycle; its data is compared in the next cycle.
            rd_addr     = scan_idx_ff;
            pend_in     = 1'b1;
            pend_idx_in = scan_idx_ff;
            scan_idx_in = scan_next;
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if ((scan_cnt_ff + 1'b1) == count_ff) begin
               state_in = S_SCAN_END;
            end
         end

         S_SCAN_END: begin
            state_in = S_PICK;
         end

         S_PICK: begin
            best_idx_in = cand;
            if (!cand_ok || (cur_present_ff && (cand == cur_ff))) begin
               res_status_in = STAT_NO_SWITCH;
               state_in      = S_RESP;
            end else if (cur_present_ff) begin
               state_in = S_PREV_RD;
            end else begin
               state_in = S_NEXT_WR;
            end
         end

         S_PREV_RD: begin
            rd_addr  = cur_ff;
            state_in = S_PREV_WR;
         end

         S_PREV_WR: begin
            // Only a running task goes back to ready; sleeping and done tasks keep their state.
            if (st_rdata == TS_RUNNING) begin
               st_we    = 1'b1;
               st_waddr = cur_ff;
               st_wdata = TS_READY;
            end
            state_in = S_NEXT_WR;
         end

         S_NEXT_WR: begin
            st_we             = 1'b1;
            st_waddr          = best_idx_ff;
            st_wdata          = TS_RUNNING;
            res_status_in     = STAT_DONE;
            res_switched_in   = 1'b1;
            res_prev_valid_in = cur_present_ff;
            res_prev_id_in    = cur_present_ff ? cur_ff : '0;
            cur_in            = best_idx_ff;
            cur_present_in    = 1'b1;
            state_in          = S_RESP;
         end

         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = res_status_ff;
               rsp_new_id_in     = res_new_id_ff;
               rsp_switched_in   = res_switched_ff;
               rsp_prev_valid_in = res_prev_valid_ff;
               rsp_prev_id_in    = res_prev_id_ff;
               rsp_cur_valid_in  = cur_present_ff;
               rsp_cur_id_in     = cur_present_ff ? cur_ff : '0;
               rsp_count_in      = count_ff;
               state_in          = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         count_ff        <= '0;
         cur_ff          <= '0;
         cur_present_ff  <= 1'b0;
         enabled_ff      <= 1'b0;
         idle_present_ff <= 1'b0;
         pend_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         cur_ff          <= cur_in;
         cur_present_ff  <= cur_present_in;
         enabled_ff      <= enabled_in;
         idle_present_ff <= idle_present_in;
         pend_ff         <= pend_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff            <= act_in;
      tid_ff            <= tid_in;
      nice_ff           <= nice_in;
      scan_idx_ff       <= scan_idx_in;
      scan_cnt_ff       <= scan_cnt_in;
      pend_idx_ff       <= pend_idx_in;
      best_found_ff     <= best_found_in;
      best_idx_ff       <= best_idx_in;
      best_pri_ff       <= best_pri_in;
      res_status_ff     <= res_status_in;
      res_new_id_ff     <= res_new_id_in;
      res_switched_ff   <= res_switched_in;
      res_prev_valid_ff <= res_prev_valid_in;
      res_prev_id_ff    <= res_prev_id_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_new_id_ff     <= rsp_new_id_in;
      rsp_switched_ff   <= rsp_switched_in;
      rsp_prev_valid_ff <= rsp_prev_valid_in;
      rsp_prev_id_ff    <= rsp_prev_id_in;
      rsp_cur_valid_ff  <= rsp_cur_valid_in;
      rsp_cur_id_ff     <= rsp_cur_id_in;
      rsp_count_ff      <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_new_id        = rsp_new_id_ff;
   assign rsp_switched      = rsp_switched_ff;
   assign rsp_prev_valid    = rsp_prev_valid_ff;
   assign rsp_prev_id       = rsp_prev_id_ff;
   assign rsp_current_valid = rsp_cur_valid_ff;
   assign rsp_current_id    = rsp_cur_id_ff;
   assign rsp_count_out     = rsp_count_ff;

   // The task count never exceeds the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("task count exceeds table size");

   // A current task always names an entry that exists.
   a_cur_in_table: assert property (@(posedge clock) disable iff (reset)
      cur_present_ff |-> ({1'b0, cur_ff} < count_ff))
      else $error("current task beyond task count");

   // No table write may overlap a scan, or the scan would see stale entries.
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SCAN) || (state_ff == S_SCAN_END)) |-> (!st_we && !pr_we))
      else $error("table write during scan");

   // A new response only appears after the sequencer has delivered it.
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      (!$past(rsp_valid_ff) || $past(rsp_ready)) && rsp_valid_ff
         |-> ($past(state_ff) == S_RESP))
      else $error("response produced outside the response step");

   // A switch always reports the new task as current.
   a_switch_sets_cur: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_switched_ff) |-> rsp_cur_valid_ff)
      else $error("switch without a current task");

endmodule

// ===== rtl/core/prrts_ram.sv =====
module prrts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/testbench.sv =====
module testbench
   import prrts_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // One request transaction as the driver presents it.
   typedef struct packed {
      action_type        action;
      idx_type           task_id;
      logic signed [6:0] nice;
   } sched_request_type;

   // One response transaction, laid out in port order so that a concatenation
   // of the response ports can be compared against it directly.
   typedef struct packed {
      status_type status;
      idx_type    new_id;
      logic       switched;
      logic       prev_valid;
      idx_type    prev_id;
      logic       current_valid;
      idx_type    current_id;
      cnt_type    count_out;
   } sched_outcome_type;

   localparam int         RANDOM_ITEMS = 700;
   localparam int         CALM_TAIL    = 80;   // final requests sent with no idling
   localparam int         DRAIN_CYCLES = 40;   // longer than the slowest scan
   localparam int         STALL_LIMIT  = 2000; // cycles with no transaction at all
   localparam action_type ACT_TOP_CODE = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid      = 1'b0;
   logic              req_ready;
   logic [3:0]        req_action     = '0;
   logic [2:0]        req_task_id    = '0;
   logic signed [6:0] req_nice_value = '0;

   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic [2:0] rsp_new_id;
   logic       rsp_switched;
   logic       rsp_prev_valid;
   logic [2:0] rsp_prev_id;
   logic       rsp_current_valid;
   logic [2:0] rsp_current_id;
   logic [3:0] rsp_count_out;

   priority_round_robin_task_scheduler uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_task_id       (req_task_id),
      .req_nice_value    (req_nice_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_new_id        (rsp_new_id),
      .rsp_switched      (rsp_switched),
      .rsp_prev_valid    (rsp_prev_valid),
      .rsp_prev_id       (rsp_prev_id),
      .rsp_current_valid (rsp_current_valid),
      .rsp_current_id    (rsp_current_id),
      .rsp_count_out     (rsp_count_out)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Scheduler state as this testbench tracks it. Entries at or above the
   // task count are never consulted, so their starting value is irrelevant.
   // ---------------------------------------------------------------------
   task_state_type tbl_state [MAX_ENTRIES];
   pri_type        tbl_pri   [MAX_ENTRIES];
   int             tbl_count = 0;
   int             cur_task  = 0;
   logic           cur_valid = 1'b0;
   logic           sched_on  = 1'b0;
   logic           idle_made = 1'b0;

   sched_request_type request_q [$];   // requests not yet presented
   sched_outcome_type outcome_q [$];   // predicted responses, oldest first

   int accepted_cnt = 0;
   int response_cnt = 0;
   int switch_cnt   = 0;
   int error_cnt    = 0;
   int quiet_cycles = 0;
   int cycle_cnt    = 0;
   int idle_mode    = 1;  // zero means a stretch with no idling at all

   // A new entry always lands at the end of the table, ready, most urgent.
   function automatic int append_task();
      int slot;
      slot            = tbl_count;
      tbl_state[slot] = TS_READY;
      tbl_pri[slot]   = '0;
      tbl_count       = slot + 1;
      return slot;
   endfunction

   // One circular scan starting just after the current task. The strict
   // comparison means the first entry of the best priority wins, which is
   // what gives round-robin among equals. Entry 0 is the fallback when it
   // is the idle task. A negative return means nothing can run.
   function automatic int pick_next_task();
      int idx, best, best_pri, n;
      best     = -1;
      best_pri = 1000;
      if (tbl_count == 0) begin
         return idle_made ? 0 : -1;
      end
      idx = (cur_valid && cur_task + 1 < tbl_count) ? cur_task + 1 : 0;
      for (n = 0; n < tbl_count; n++) begin
         if ((tbl_state[idx] == TS_READY || tbl_state[idx] == TS_RUNNING) &&
             int'(tbl_pri[idx]) < best_pri) begin
            best     = idx;
            best_pri = tbl_pri[idx];
         end
         idx = (idx + 1 < tbl_count) ? idx + 1 : 0;
      end
      if (best >= 0) begin
         return best;
      end
      return idle_made ? 0 : -1;
   endfunction

   // Applies one accepted request to the tracked state and returns the
   // response the block must produce for it.
   function automatic sched_outcome_type apply_request(sched_request_type rq);
      sched_outcome_type o;
      int next, nv;
      o = '0;
      case (rq.action)
         ACT_INIT: begin
            // Wipes the table and rebuilds it with the idle task running.
            tbl_count = 0;
            cur_valid = 1'b0;
            cur_task  = 0;
            sched_on  = 1'b0;
            o.new_id  = idx_type'(append_task());
            tbl_state[0] = TS_RUNNING;
            idle_made = 1'b1;
         end
         ACT_CREATE: begin
            if (tbl_count >= MAX_ENTRIES) o.status = STAT_FULL;
            else o.new_id = idx_type'(append_task());
         end
         ACT_FORK: begin
            // Missing parent is reported ahead of a full table.
            if (!cur_valid) o.status = STAT_NO_CUR;
            else if (tbl_count >= MAX_ENTRIES) o.status = STAT_FULL;
            else o.new_id = idx_type'(append_task());
         end
         ACT_SETPRI: begin
            if (int'(rq.task_id) >= tbl_count) begin
               o.status = STAT_UNKNOWN;
            end else begin
               nv = int'($signed(rq.nice));
               if (nv < NICE_MIN) nv = NICE_MIN;
               if (nv > NICE_MAX) nv = NICE_MAX;
               tbl_pri[rq.task_id] = pri_type'(nv + NICE_OFFSET);
            end
         end
         ACT_SLEEP, ACT_EXIT: begin
            if (!cur_valid) o.status = STAT_NO_CUR;
            else tbl_state[cur_task] = (rq.action == ACT_SLEEP) ? TS_SLEEPING : TS_DONE;
         end
         ACT_START, ACT_TICK: begin
            // Start schedules even while disabled; tick does not.
            if (rq.action == ACT_TICK && (!sched_on || tbl_count == 0)) begin
               o.status = STAT_NO_SWITCH;
            end else begin
               next = pick_next_task();
               if (next < 0 || (cur_valid && next == cur_task)) begin
                  o.status = STAT_NO_SWITCH;
               end else begin
                  if (cur_valid) begin
                     o.prev_valid = 1'b1;
                     o.prev_id    = idx_type'(cur_task);
                     // Sleeping and finished tasks stay where they are.
                     if (tbl_state[cur_task] == TS_RUNNING) tbl_state[cur_task] = TS_READY;
                  end
                  tbl_state[next] = TS_RUNNING;
                  cur_task   = next;
                  cur_valid  = 1'b1;
                  o.switched = 1'b1;
               end
            end
         end
         ACT_ENABLE:  sched_on = 1'b1;
         ACT_DISABLE: sched_on = 1'b0;
         default: ;  // unused codes change nothing and report done
      endcase
      o.current_valid = cur_valid;
      o.current_id    = cur_valid ? idx_type'(cur_task) : '0;
      o.count_out     = cnt_type'(tbl_count);
      return o;
   endfunction

   function automatic void push_req(action_type a, int tid, int nice);
      sched_request_type rq;
      rq.action  = a;
      rq.task_id = idx_type'(tid);
      rq.nice    = nice[6:0];
      request_q.push_back(rq);
   endfunction

   // Half the time values near the clamp limits, otherwise anything the field holds.
   function automatic int random_nice();
      if ($urandom_range(0, 1) == 0) return $urandom_range(0, 47) - 24;
      return $urandom_range(0, 127);
   endfunction

   function automatic string outcome_str(sched_outcome_type o);
      return $sformatf("status=%0d new_id=%0d switched=%0d prev=%0d/%0d cur=%0d/%0d count=%0d",
                       o.status, o.new_id, o.switched, o.prev_valid, o.prev_id,
                       o.current_valid, o.current_id, o.count_out);
   endfunction

   // ---------------------------------------------------------------------
   // Request driver. A transaction is predicted at the edge where it is
   // accepted. The next item goes out on the same edge, so valid is never
   // dropped and raised within one step. Gaps come in bursts, except during
   // no-idle stretches and during the final part of the run.
   // ---------------------------------------------------------------------
   sched_request_type held_req;
   int                gap_left = 0;

   always @(posedge clock) begin
      sched_request_type rq;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            outcome_q.push_back(apply_request(held_req));
            accepted_cnt++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left == 0 && idle_mode != 0 && request_q.size() > CALM_TAIL &&
                $urandom_range(0, 4) == 0) begin
               gap_left = $urandom_range(1, 8);
            end
            if (gap_left > 0 || request_q.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               rq              = request_q.pop_front();
               held_req        = rq;
               req_action     <= rq.action;
               req_task_id    <= rq.task_id;
               req_nice_value <= rq.nice;
               req_valid      <= 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor. Every accepted response is matched against the
   // oldest prediction; a response with nothing predicted is an error too.
   // ---------------------------------------------------------------------
   int stall_left = 0;

   always @(posedge clock) begin
      sched_outcome_type seen, want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_status, rsp_new_id, rsp_switched, rsp_prev_valid, rsp_prev_id,
                    rsp_current_valid, rsp_current_id, rsp_count_out};
            response_cnt++;
            if (rsp_switched) switch_cnt++;
            if (outcome_q.size() == 0) begin
               error_cnt++;
               if (error_cnt <= 10)
                  $display("unexpected response at %0t: %s", $realtime, outcome_str(seen));
            end else begin
               want = outcome_q.pop_front();
               if (seen !== want) begin
                  error_cnt++;
                  if (error_cnt <= 10) begin
                     $display("response %0d mismatch at %0t", response_cnt, $realtime);
                     $display("   expected %s", outcome_str(want));
                     $display("   actual   %s", outcome_str(seen));
                  end
               end
            end
         end
         if (stall_left == 0 && idle_mode != 0 && request_q.size() > CALM_TAIL &&
             $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 8);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // The idling mode is re-rolled periodically from the cycle counter, so some stretches run
   // with no gaps or stalls at all. The same block keeps the watchdog count
   // of cycles in which neither channel moved a transaction.
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt % 64 == 0) idle_mode <= $urandom_range(0, 3);
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("timeout: no transaction for %0d cycles, %0d predictions outstanding",
               STALL_LIMIT, outcome_q.size());
      $display("testbench: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run.
   // ---------------------------------------------------------------------
   initial begin
      int n_directed, r, a;

      // Directed part. It opens with an empty table, where nothing can be
      // scheduled and every action that needs a current task is refused.
      push_req(ACT_START,   0, 0);    // empty table, no idle task: no switch
      push_req(ACT_ENABLE,  0, 0);
      push_req(ACT_TICK,    0, 0);    // enabled but empty: no switch
      push_req(ACT_SLEEP,   0, 0);    // no current task
      push_req(ACT_FORK,    0, 0);    // fork needs a parent
      push_req(ACT_SETPRI,  0, 5);    // entry 0 does not exist yet
      push_req(ACT_CREATE,  7, 0);    // entry 0 before any init
      push_req(ACT_INIT,    5, -1);   // rebuild with the idle task, disabled
      push_req(ACT_TICK,    0, 0);    // disabled: no switch
      push_req(ACT_START,   0, 0);    // start ignores the enable flag
      push_req(ACT_ENABLE,  0, 0);
      repeat (6) push_req(ACT_FORK, 0, 0);
      push_req(ACT_CREATE,  0, 0);    // table now full
      push_req(ACT_CREATE,  0, 0);    // full
      push_req(ACT_FORK,    0, 0);    // full
      push_req(ACT_SETPRI,  7, -64);  // clamps to the most urgent level
      push_req(ACT_SETPRI,  3, 63);   // clamps to the least urgent level
      push_req(ACT_SETPRI,  2, -21);
      push_req(ACT_SETPRI,  4, 20);
      push_req(ACT_TICK,    0, 0);
      push_req(ACT_SLEEP,   0, 0);
      push_req(ACT_TICK,    0, 0);    // a sleeping task is not revived
      push_req(ACT_EXIT,    0, 0);
      push_req(ACT_START,   0, 0);
      push_req(ACT_DISABLE, 0, 0);
      push_req(ACT_TICK,    0, 0);
      push_req(ACT_TOP_CODE, 7, 63);  // unused code
      n_directed = request_q.size();

      // Random part, in episodes. Most episodes start from a clean table with
      // scheduling on and a few tasks of mixed priority, then run a random
      // mix weighted toward ticks. A few skip the setup and act as noise.
      while (request_q.size() < n_directed + RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) != 0) begin
            push_req(ACT_INIT, $urandom_range(0, 7), random_nice());
            push_req(ACT_ENABLE, $urandom_range(0, 7), random_nice());
            repeat ($urandom_range(1, 7)) begin
               push_req(ACT_CREATE, $urandom_range(0, 7), random_nice());
               push_req(ACT_SETPRI, $urandom_range(0, 7), random_nice());
            end
         end
         repeat ($urandom_range(15, 40)) begin
            r = $urandom_range(0, 99);
            if      (r < 2)  a = ACT_INIT;
            else if (r < 12) a = ACT_CREATE;
            else if (r < 20) a = ACT_FORK;
            else if (r < 36) a = ACT_SETPRI;
            else if (r < 43) a = ACT_SLEEP;
            else if (r < 48) a = ACT_EXIT;
            else if (r < 58) a = ACT_START;
            else if (r < 86) a = ACT_TICK;
            else if (r < 91) a = ACT_ENABLE;
            else if (r < 95) a = ACT_DISABLE;
            else a = $urandom_range(int'(ACT_DISABLE) + 1, int'(ACT_TOP_CODE));
            push_req(action_type'(a), $urandom_range(0, 7), random_nice());
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request to go in and every predicted response to
      // come back, then give the block time to show any stray response.
      while (request_q.size() != 0 || req_valid || outcome_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d requests (%0d directed) and %0d responses",
               accepted_cnt, n_directed, response_cnt);
      $display("scheduler switched tasks %0d times; %0d mismatches", switch_cnt, error_cnt);
      if (error_cnt == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
